// ===== rtl/core/sobel_gradient_magnitude_macros.svh =====
// ---------------------------------------------------------------------------
// Sobel gradient magnitude: assertion macros
// Shared concurrent assertion forms; ASSERT_OFF compiles them out.
// ---------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SGM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgm assertion failed");

// next-cycle implication
`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgm assertion failed");

`else

`define SGM_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SGM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/sgm_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel gradient magnitude: package
// Field widths, register indexes and the control state type.
// ---------------------------------------------------------------------------
package sgm_pkg;

   localparam int PIXEL_WIDTH     = 8;
   localparam int MAG_WIDTH       = 11;
   localparam int ROW_WIDTH       = 16;
   localparam int COL_OUT_WIDTH   = 10;
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // |gx|, |gy| <= 1020; sum of squares needs one more bit than a square
   localparam int GRAD_WIDTH = 10;
   localparam int SUM_WIDTH  = 2 * GRAD_WIDTH + 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [ROW_WIDTH-1:0]      HEIGHT_RESET = 16'd1024;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } sgm_state_type;

endpackage

// ===== rtl/core/sgm_isqrt.sv =====
// ---------------------------------------------------------------------------
// Sobel gradient magnitude: integer square root
// Restoring digit-by-digit floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module sgm_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sgm_pkg::SUM_WIDTH-1:0]   radicand,
   output logic                            done,
   output logic [sgm_pkg::MAG_WIDTH-1:0]   root
);
   import sgm_pkg::*;

   localparam int RAD_W = 2 * MAG_WIDTH;
   localparam int REM_W = MAG_WIDTH + 3;
   localparam int CNT_W = $clog2(MAG_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RAD_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] root_ff, root_in;

   logic [REM_W-1:0]     rem_shift;
   logic [REM_W-1:0]     trial;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = RAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/sobel_gradient_magnitude.sv =====
// ---------------------------------------------------------------------------
// Sobel gradient magnitude
// Streaming 3x3 Sobel filter: line stores in RAM, floor(sqrt(gx^2+gy^2)).
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake              beat carries
//   -------  ---  ---------------------  -------------------------------------
//   csr      in   csr_valid/csr_ready    csr_index, csr_wdata (register write)
//   req      in   req_valid/req_ready    req_pixel, raster order
//   rsp      out  rsp_valid/rsp_ready    magnitude, center row/col, max, last
//
// One pixel is in work at a time. A border pixel passes through accept,
// then line store read and write back. An interior pixel goes through
// accept, read, square, 11 steps of the bit-serial square root, hand-off.
// The result sits in an output register, so the next pixel is accepted while
// a result waits on rsp_ready. csr_ready is always high.
// Reset is synchronous; the line stores are not cleared and hold nothing
// meaningful until the first two rows of a frame have passed.
// ---------------------------------------------------------------------------
`include "sobel_gradient_magnitude_macros.svh"

module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sgm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sgm_pkg::PIXEL_WIDTH-1:0]      req_pixel,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sgm_pkg::MAG_WIDTH-1:0]        rsp_magnitude,
   output logic [sgm_pkg::ROW_WIDTH-1:0]        rsp_center_row,
   output logic [sgm_pkg::COL_OUT_WIDTH-1:0]    rsp_center_col,
   output logic [sgm_pkg::MAG_WIDTH-1:0]        rsp_frame_max,
   output logic                                 rsp_last
);
   import sgm_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // weighted 1-2-1 sum of three taps
   function automatic logic [GRAD_WIDTH-1:0] ksum(
      input logic [PIXEL_WIDTH-1:0] a,
      input logic [PIXEL_WIDTH-1:0] b,
      input logic [PIXEL_WIDTH-1:0] c
   );
      return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   // ---------------- control ----------------
   sgm_state_type state_ff, state_in;

   logic req_accept;
   logic mem_we;
   logic sqrt_start;
   logic sqrt_done;
   logic rsp_load;
   logic produce;

   // ---------------- config ----------------
   logic [CFG_WIDTH_BITS-1:0] width_ff;
   logic [ROW_WIDTH-1:0]      height_ff;
   logic [COL_W-1:0]          col_last;
   logic [ROW_WIDTH-1:0]      row_last;

   // ---------------- position ----------------
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_WIDTH-1:0] row_ff, row_in;
   logic [COL_W-1:0]     col_eff;
   logic [ROW_WIDTH-1:0] row_eff;
   logic [COL_W-1:0]     col_cur_ff;
   logic [ROW_WIDTH-1:0] row_cur_ff;
   logic [PIXEL_WIDTH-1:0] pixel_ff;

   // ---------------- line stores ----------------
   logic [PIXEL_WIDTH-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0] middle_mem [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0] upper_rd_ff;
   logic [PIXEL_WIDTH-1:0] middle_rd_ff;

   // window: columns c-2 then c-1, each top, middle, bottom
   logic [PIXEL_WIDTH-1:0] win_ff [6];

   // ---------------- gradient / result ----------------
   logic [GRAD_WIDTH-1:0] sum_right, sum_left, sum_top, sum_bot;
   logic [GRAD_WIDTH-1:0] gx_abs, gy_abs;
   logic [GRAD_WIDTH-1:0] gx_abs_ff, gy_abs_ff;
   logic [2*GRAD_WIDTH-1:0] sq_x, sq_y;
   logic [SUM_WIDTH-1:0]  radicand;
   logic [MAG_WIDTH-1:0]  sqrt_root;
   logic [MAG_WIDTH-1:0]  frame_max;

   logic [ROW_WIDTH-1:0]     row_out_ff;
   logic [COL_OUT_WIDTH-1:0] col_out_ff;
   logic                     last_ff;
   logic [MAG_WIDTH-1:0]     max_ff;

   logic                     rsp_valid_ff;
   logic [MAG_WIDTH-1:0]     rsp_mag_ff;
   logic [ROW_WIDTH-1:0]     rsp_row_ff;
   logic [COL_OUT_WIDTH-1:0] rsp_col_ff;
   logic [MAG_WIDTH-1:0]     rsp_max_ff;
   logic                     rsp_last_ff;

   // ------------------------------------------------------------------------
   // Config registers. Width clamps to 3..MAX_WIDTH, height to at least 3.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < CFG_WIDTH_BITS'(3))
         col_last = COL_W'(2);
      else if (32'(width_ff) > MAX_WIDTH)
         col_last = COL_W'(MAX_WIDTH - 1);
      else
         col_last = COL_W'(width_ff - CFG_WIDTH_BITS'(1));
      if (height_ff < ROW_WIDTH'(3))
         row_last = ROW_WIDTH'(2);
      else
         row_last = height_ff - ROW_WIDTH'(1);
   end

   // a counter past its limit (after a mid-frame write) acts as the limit
   assign col_eff = (col_ff > col_last) ? col_last : col_ff;
   assign row_eff = (row_ff > row_last) ? row_last : row_ff;

   // ------------------------------------------------------------------------
   // Control FSM
   // ------------------------------------------------------------------------
   assign produce = (row_cur_ff >= ROW_WIDTH'(2)) && (col_cur_ff >= COL_W'(2));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ:   state_in = produce ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (sqrt_done) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_READ:   mem_we     = 1'b1;
         ST_SQUARE: sqrt_start = 1'b1;
         ST_ROOT:   ;
         ST_DONE:   rsp_load   = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ------------------------------------------------------------------------
   // Accept: latch pixel and position, launch the line store read.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pixel_ff   <= req_pixel;
         col_cur_ff <= col_eff;
         row_cur_ff <= row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         upper_rd_ff  <= upper_mem[col_eff];
         middle_rd_ff <= middle_mem[col_eff];
      end
   end

   // write back in the cycle after accept; only one pixel is in work, so no overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[col_cur_ff]  <= middle_rd_ff;
         middle_mem[col_cur_ff] <= pixel_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Read cycle: gradients, window shift, counter advance.
   // ------------------------------------------------------------------------
   assign sum_right = ksum(upper_rd_ff, middle_rd_ff, pixel_ff);
   assign sum_left  = ksum(win_ff[0], win_ff[1], win_ff[2]);
   assign sum_top   = ksum(win_ff[0], win_ff[3], upper_rd_ff);
   assign sum_bot   = ksum(win_ff[2], win_ff[5], pixel_ff);

   assign gx_abs = (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
   assign gy_abs = (sum_top >= sum_bot) ? sum_top - sum_bot : sum_bot - sum_top;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (mem_we) begin
         if (col_cur_ff == col_last) begin
            col_in = '0;
            row_in = (row_cur_ff == row_last) ? '0 : row_cur_ff + 1'b1;
         end else begin
            col_in = col_cur_ff + 1'b1;
            row_in = row_cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (mem_we) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= upper_rd_ff;
            win_ff[4] <= middle_rd_ff;
            win_ff[5] <= pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gx_abs_ff  <= gx_abs;
         gy_abs_ff  <= gy_abs;
         row_out_ff <= row_cur_ff - 1'b1;
         col_out_ff <= COL_OUT_WIDTH'(32'(col_cur_ff) - 32'd1);
         last_ff    <= (row_cur_ff == row_last) && (col_cur_ff == col_last);
      end
   end

   // ------------------------------------------------------------------------
   // Square and root
   // ------------------------------------------------------------------------
   assign sq_x     = gx_abs_ff * gx_abs_ff;
   assign sq_y     = gy_abs_ff * gy_abs_ff;
   assign radicand = {1'b0, sq_x} + {1'b0, sq_y};

   sgm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // ------------------------------------------------------------------------
   // Frame max and output register. The max clears after the frame's last
   // interior pixel, which is always the one that wraps the counters.
   // ------------------------------------------------------------------------
   assign frame_max = (sqrt_root > max_ff) ? sqrt_root : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            max_ff       <= last_ff ? '0 : frame_max;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mag_ff  <= sqrt_root;
         rsp_row_ff  <= row_out_ff;
         rsp_col_ff  <= col_out_ff;
         rsp_max_ff  <= frame_max;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_frame_max  = rsp_max_ff;
   assign rsp_last       = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `SGM_ASSERT_IMPL(a_wb_after_accept, clock, reset, mem_we, $past(req_valid && req_ready))
   `SGM_ASSERT_IMPL(a_root_in_root_state, clock, reset, sqrt_done, state_ff == ST_ROOT)
   `SGM_ASSERT_IMPL(a_max_covers_mag, clock, reset, rsp_valid_ff, rsp_max_ff >= rsp_mag_ff)
   `SGM_ASSERT_NEXT(a_max_clear_at_end, clock, reset, rsp_load && last_ff, max_ff == '0)

endmodule
